### sv/ssd_pkg.sv
package ssd_pkg;

   localparam logic [7:0] END_BYTE     = 8'hC0;
   localparam logic [7:0] ESC_BYTE     = 8'hDB;
   localparam logic [7:0] ESC_END_BYTE = 8'hDC;
   localparam logic [7:0] ESC_ESC_BYTE = 8'hDD;

   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   localparam int TOKQ_DEPTH = 4;
   localparam int TOKQ_AW    = $clog2(TOKQ_DEPTH);
   localparam int RESQ_DEPTH = 2;
   localparam int RESQ_AW    = $clog2(RESQ_DEPTH);

   typedef enum logic [2:0] {
      KIND_PLAIN,
      KIND_END,
      KIND_ESC,
      KIND_ESC_END,
      KIND_ESC_ESC
   } kind_type;

   typedef enum logic [1:0] {
      EV_DATA  = 2'd0,
      EV_DONE  = 2'd1,
      EV_ABORT = 2'd2
   } event_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data;
   } token_type;

   typedef struct packed {
      logic        valid;
      token_type   tok;
   } token_link_type;

   typedef struct packed {
      event_type   ev;
      logic [7:0]  data;
      logic [15:0] length;
   } result_type;

endpackage

### sv/slip_stream_deframer.sv
// SLIP stream deframer.
// Request channel: present one received byte on req_in_byte with push high;
// the byte is taken at a rising edge where push is high and full is low.
// Result channel: while empty is low the oldest result sits on rsp_event_res,
// rsp_data_byte and rsp_packet_length; raise pop to take it.
// rsp_event_res: data byte, packet complete (with length), or packet aborted
// on a bad escape. Bytes outside a packet and ESC bytes give no result.
// A taken byte is held in the token queue; the decoder takes it from there and
// writes its result into the result queue, from which it can then be popped.
// Throughput: one byte per cycle, sustained while results are popped; the decoder
// consumes one token from a four-entry token queue each cycle the result queue is
// not full, and writes at most one result into a two-entry result queue.
// Reset clears both queues and returns the decoder to hunting for END.
// When the receiver stalls, the result queue fills, the decoder holds, the
// token queue fills and full rises; nothing is dropped.
module slip_stream_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_in_byte,
   output logic        empty,
   input  logic        pop,
   output logic [1:0]  rsp_event_res,
   output logic [7:0]  rsp_data_byte,
   output logic [15:0] rsp_packet_length
);

   ssd_pkg::token_link_type link;
   ssd_pkg::result_type     res;
   logic                    tok_pop;

   ssd_front u_front (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .in_byte (req_in_byte),
      .full    (full),
      .link    (link),
      .tok_pop (tok_pop)
   );

   ssd_back u_back (
      .clock   (clock),
      .reset   (reset),
      .link    (link),
      .tok_pop (tok_pop),
      .empty   (empty),
      .pop     (pop),
      .res     (res)
   );

   assign rsp_event_res     = res.ev;
   assign rsp_data_byte     = res.data;
   assign rsp_packet_length = res.length;

endmodule

### sv/ssd_front.sv
module ssd_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  logic [7:0]              in_byte,
   output logic                    full,
   output ssd_pkg::token_link_type link,
   input  logic                    tok_pop
);

   ssd_pkg::token_type            q_ff [ssd_pkg::TOKQ_DEPTH];
   logic [ssd_pkg::TOKQ_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [ssd_pkg::TOKQ_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [ssd_pkg::TOKQ_AW:0]     count_ff, count_in;
   ssd_pkg::token_type            tok_new;
   logic                          accept;
   logic                          take;

   localparam logic [ssd_pkg::TOKQ_AW:0]   FULL_COUNT = (ssd_pkg::TOKQ_AW+1)'(ssd_pkg::TOKQ_DEPTH);
   localparam logic [ssd_pkg::TOKQ_AW-1:0] LAST_PTR   = ssd_pkg::TOKQ_AW'(ssd_pkg::TOKQ_DEPTH - 1);

   always_comb begin
      tok_new.data = in_byte;
      unique case (in_byte)
         ssd_pkg::END_BYTE:     tok_new.kind = ssd_pkg::KIND_END;
         ssd_pkg::ESC_BYTE:     tok_new.kind = ssd_pkg::KIND_ESC;
         ssd_pkg::ESC_END_BYTE: tok_new.kind = ssd_pkg::KIND_ESC_END;
         ssd_pkg::ESC_ESC_BYTE: tok_new.kind = ssd_pkg::KIND_ESC_ESC;
         default:               tok_new.kind = ssd_pkg::KIND_PLAIN;
      endcase
   end

   assign full       = (count_ff == FULL_COUNT);
   assign accept     = push && !full;
   assign link.valid = (count_ff != '0);
   assign link.tok   = q_ff[rd_ptr_ff];
   assign take       = tok_pop && link.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (accept) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (take) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (accept && !take) begin
         count_in = count_ff + 1'b1;
      end else if (take && !accept) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         q_ff[wr_ptr_ff] <= tok_new;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("token queue count out of range");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (accept && !take) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("token queue count missed a request");

   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      (full && !take) |=> full)
      else $error("token queue lost an entry while full");
`endif

endmodule

### sv/ssd_back.sv
module ssd_back (
   input  logic                    clock,
   input  logic                    reset,
   input  ssd_pkg::token_link_type link,
   output logic                    tok_pop,
   output logic                    empty,
   input  logic                    pop,
   output ssd_pkg::result_type     res
);

   typedef enum logic [1:0] {
      ST_HUNT,
      ST_BODY,
      ST_ESCAPED
   } state_type;

   localparam logic [ssd_pkg::RESQ_AW:0]   FULL_COUNT = (ssd_pkg::RESQ_AW+1)'(ssd_pkg::RESQ_DEPTH);
   localparam logic [ssd_pkg::RESQ_AW-1:0] LAST_PTR   = ssd_pkg::RESQ_AW'(ssd_pkg::RESQ_DEPTH - 1);

   state_type                     state_ff, state_in;
   logic [15:0]                   byte_count_ff, byte_count_in;
   ssd_pkg::result_type           q_ff [ssd_pkg::RESQ_DEPTH];
   logic [ssd_pkg::RESQ_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [ssd_pkg::RESQ_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [ssd_pkg::RESQ_AW:0]     count_ff, count_in;
   logic                          take;
   logic                          emit;
   logic                          drain;
   logic [15:0]                   count_inc;
   ssd_pkg::result_type           res_new;

   assign tok_pop   = (count_ff != FULL_COUNT);
   assign take      = tok_pop && link.valid;
   assign empty     = (count_ff == '0);
   assign drain     = pop && !empty;
   assign res       = q_ff[rd_ptr_ff];
   assign count_inc = (byte_count_ff == ssd_pkg::COUNT_MAX) ? byte_count_ff
                                                           : byte_count_ff + 16'd1;

   always_comb begin
      state_in      = state_ff;
      byte_count_in = byte_count_ff;
      emit          = 1'b0;
      res_new.ev     = ssd_pkg::EV_DATA;
      res_new.data   = link.tok.data;
      res_new.length = '0;
      if (take) begin
         unique case (state_ff)
            ST_HUNT: begin
               if (link.tok.kind == ssd_pkg::KIND_END) begin
                  state_in      = ST_BODY;
                  byte_count_in = '0;
               end
            end
            ST_BODY: begin
               case (link.tok.kind)
                  ssd_pkg::KIND_END: begin
                     state_in       = ST_HUNT;
                     byte_count_in  = '0;
                     emit           = (byte_count_ff != '0);
                     res_new.ev     = ssd_pkg::EV_DONE;
                     res_new.data   = '0;
                     res_new.length = byte_count_ff;
                  end
                  ssd_pkg::KIND_ESC: begin
                     state_in = ST_ESCAPED;
                  end
                  default: begin
                     byte_count_in = count_inc;
                     emit          = 1'b1;
                  end
               endcase
            end
            ST_ESCAPED: begin
               case (link.tok.kind)
                  ssd_pkg::KIND_END: begin
                     // END wins over an armed escape
                     state_in       = ST_HUNT;
                     byte_count_in  = '0;
                     emit           = (byte_count_ff != '0);
                     res_new.ev     = ssd_pkg::EV_DONE;
                     res_new.data   = '0;
                     res_new.length = byte_count_ff;
                  end
                  ssd_pkg::KIND_ESC: begin
                     state_in = ST_ESCAPED;
                  end
                  ssd_pkg::KIND_ESC_ESC: begin
                     state_in      = ST_BODY;
                     byte_count_in = count_inc;
                     emit          = 1'b1;
                     res_new.data  = ssd_pkg::ESC_BYTE;
                  end
                  ssd_pkg::KIND_ESC_END: begin
                     state_in      = ST_BODY;
                     byte_count_in = count_inc;
                     emit          = 1'b1;
                     res_new.data  = ssd_pkg::END_BYTE;
                  end
                  default: begin
                     // bad escape: drop the packet and hunt
                     state_in      = ST_HUNT;
                     byte_count_in = '0;
                     emit          = 1'b1;
                     res_new.ev    = ssd_pkg::EV_ABORT;
                     res_new.data  = '0;
                  end
               endcase
            end
            default: begin
               state_in = ST_HUNT;
            end
         endcase
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (emit) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (drain) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (emit && !drain) begin
         count_in = count_ff + 1'b1;
      end else if (drain && !emit) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_HUNT;
         byte_count_ff <= '0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         byte_count_ff <= byte_count_in;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         count_ff      <= count_in;
      end
      if (emit) begin
         q_ff[wr_ptr_ff] <= res_new;
      end
   end

`ifndef NO_ASSERTIONS
   a_hunt_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HUNT) |-> (byte_count_ff == '0))
      else $error("byte count left over while hunting");

   a_no_empty_done: assert property (@(posedge clock) disable iff (reset)
      (emit && res_new.ev == ssd_pkg::EV_DONE) |-> (res_new.length != '0))
      else $error("empty packet reported as complete");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      emit |-> (count_ff != FULL_COUNT))
      else $error("result queue overflow");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      (!take) |=> (byte_count_ff == $past(byte_count_ff)))
      else $error("byte count moved without a token");
`endif

endmodule
